@@ rtl/core/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg: shared types for the decimal digit accumulator
// Beat payloads, operation codes, cell control and a small divide by ten.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int OPERAND_W  = 31;
  localparam int DIGIT_W    = 4;
  // decimal digits needed to hold the widest operand
  localparam int BCD_DIGITS = 10;
  // cell carry runs 0..18
  localparam int CARRY_W    = 5;
  // cell sum d*v + c runs 0..99
  localparam int SUM_W      = 7;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [OPERAND_W-1:0] operand;
  } in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } out_t;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
    logic mul;
  } cell_ctrl_t;

  // Split a value of 0..99 into quotient and remainder by ten.
  function automatic logic [7:0] div10(input logic [SUM_W-1:0] s);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(s) * 15'd205;
    q = p[14:11];
    r = s - 7'(q) * 7'd10;
    return {q, r[3:0]};
  endfunction

endpackage

@@ rtl/core/dda_cell.sv @@
// ----------------------------------------------------------------------------
// dda_cell: one decimal position of the operand and carry chain
// Holds one operand digit and one carry of 0..18; converts, shifts or multiplies.
// ----------------------------------------------------------------------------
module dda_cell (
  input  logic                        clk,
  input  dda_pkg::cell_ctrl_t         ctrl,
  input  logic [dda_pkg::DIGIT_W-1:0] d,
  input  logic                        bit_in,
  output logic                        bit_out,
  input  logic [dda_pkg::DIGIT_W-1:0] v_up,
  output logic [dda_pkg::DIGIT_W-1:0] v,
  input  logic [dda_pkg::DIGIT_W-1:0] b_up,
  output logic [dda_pkg::DIGIT_W-1:0] b
);
  import dda_pkg::*;

  logic [CARRY_W-1:0] c;
  logic [DIGIT_W-1:0] adj;
  logic [SUM_W-1:0]   s;
  logic [7:0]         qr;

  // double dabble: add three before the shift when the digit is five or more
  assign adj     = (v >= 4'd5) ? v + 4'd3 : v;
  assign bit_out = adj[3];

  assign s  = SUM_W'(d) * SUM_W'(v) + SUM_W'(c);
  assign qr = div10(s);
  assign b  = qr[3:0];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      v <= '0;
      c <= '0;
    end else if (ctrl.conv) begin
      v <= {adj[2:0], bit_in};
    end else if (ctrl.shift) begin
      v <= v_up;
    end else if (ctrl.mul) begin
      // keep the low part of the upper neighbor, absorb our own tens
      c <= CARRY_W'(b_up) + CARRY_W'(qr[7:4]);
    end
  end

endmodule

@@ rtl/core/decimal_digit_accumulator.sv @@
// ----------------------------------------------------------------------------
// decimal_digit_accumulator: fixed-length decimal number, load/add/mul/read
// Digit ring of DIGITS cells plus a ten-cell operand chain for exact multiply.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload            handshake
//   in       in         op, operand        in_valid / in_stall
//   out      out        digit, last        out_valid / out_stall
//
// Load, add and multiply run 31 double dabble steps that turn the operand
// into ten decimal digits, then the digit ring rotates once, one digit per
// cycle through the operand chain. Read takes one ring step per digit looked
// at and waits out any out_stall. A synchronous reset clears the stored
// number to zero. A stalled output beat holds the ring in read; a new item
// is taken while the last beat of a read still waits.
//
module decimal_digit_accumulator #(
  parameter int DIGITS = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dda_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dda_pkg::out_t out_data
);
  import dda_pkg::*;

  localparam int CNT_MAX = (DIGITS > OPERAND_W) ? DIGITS : OPERAND_W;
  localparam int CNT_W   = $clog2(CNT_MAX);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt;
  op_t                  op_q;
  logic [OPERAND_W-1:0] bin;
  logic                 acarry;
  logic                 started;
  logic [DIGIT_W-1:0]   store [DIGITS];
  logic                 res_valid;
  out_t                 res_data;

  logic accept, conv_last, ring_last, slot_free, run_step, read_step, emit;
  logic [DIGIT_W-1:0] cur_top, new_digit;
  logic [DIGIT_W:0]   add_sum;
  cell_ctrl_t         ctrl;

  logic [DIGIT_W-1:0] v_chain [BCD_DIGITS+1];
  logic [DIGIT_W-1:0] b_chain [BCD_DIGITS+1];
  logic               bit_chain [BCD_DIGITS+1];

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign conv_last = (cnt == CNT_W'(OPERAND_W - 1));
  assign ring_last = (cnt == CNT_W'(DIGITS - 1));

  // read advances only when the output register is free or drains this cycle
  assign slot_free = !res_valid || !out_stall;
  assign run_step  = (state == ST_RUN);
  assign read_step = (state == ST_READ) && slot_free;

  // --- operand chain -------------------------------------------------------
  assign ctrl.clear = accept;
  assign ctrl.conv  = (state == ST_CONV);
  assign ctrl.shift = run_step && (op_q == OP_LOAD || op_q == OP_ADD);
  assign ctrl.mul   = run_step && (op_q == OP_MUL);

  assign bit_chain[0]          = bin[OPERAND_W-1];
  assign v_chain[BCD_DIGITS]   = '0;
  assign b_chain[BCD_DIGITS]   = '0;

  for (genvar j = 0; j < BCD_DIGITS; j++) begin : g_cell
    dda_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .d       (store[0]),
      .bit_in  (bit_chain[j]),
      .bit_out (bit_chain[j+1]),
      .v_up    (v_chain[j+1]),
      .v       (v_chain[j]),
      .b_up    (b_chain[j+1]),
      .b       (b_chain[j])
    );
  end

  // --- digit produced at the ring head ---------------------------------------
  assign add_sum = (DIGIT_W+1)'(store[0]) + (DIGIT_W+1)'(v_chain[0])
                 + (DIGIT_W+1)'(acarry);

  always_comb begin
    case (op_q)
      OP_LOAD: new_digit = v_chain[0];
      OP_ADD:  new_digit = (add_sum >= 5'd10) ? DIGIT_W'(add_sum - 5'd10)
                                              : add_sum[DIGIT_W-1:0];
      OP_MUL:  new_digit = b_chain[0];
      default: new_digit = store[0];
    endcase
  end

  // --- read selection ----------------------------------------------------------
  assign cur_top = store[DIGITS-1];
  // drop leading zeros, but always emit the least significant digit
  assign emit    = started || (cur_top != '0) || ring_last;

  // --- control ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) begin
        state_next = (in_data.op == OP_READ) ? ST_READ : ST_CONV;
      end
      ST_CONV: if (conv_last) begin
        state_next = ST_RUN;
      end
      ST_RUN:  if (ring_last) begin
        state_next = ST_IDLE;
      end
      ST_READ: if (read_step && ring_last) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept || (state == ST_CONV && conv_last) || (run_step && ring_last)) begin
        cnt <= '0;
      end else if (state == ST_CONV || run_step || read_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= in_data.op;
      bin     <= in_data.operand;
      acarry  <= 1'b0;
      started <= 1'b0;
    end else begin
      if (state == ST_CONV) begin
        bin <= {bin[OPERAND_W-2:0], 1'b0};
      end
      if (run_step) begin
        acarry <= (add_sum >= 5'd10);
      end
      if (read_step && emit) begin
        started <= 1'b1;
      end
    end
  end

  // --- digit ring: rotate down on a pass, up on a read -----------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        store[i] <= '0;
      end
    end else if (run_step) begin
      for (int i = 0; i < DIGITS - 1; i++) begin
        store[i] <= store[i+1];
      end
      store[DIGITS-1] <= new_digit;
    end else if (read_step) begin
      for (int i = 1; i < DIGITS; i++) begin
        store[i] <= store[i-1];
      end
      store[0] <= cur_top;
    end
  end

  // --- output register ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (read_step && emit) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_step && emit) begin
      res_data.digit <= cur_top;
      res_data.last  <= ring_last;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_data;

  // --- assertions --------------------------------------------------------------
  a_top_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    cur_top <= 4'd9)
    else $error("stored digit out of decimal range");

  a_out_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.digit <= 4'd9)
    else $error("output digit out of decimal range");

  a_inner_beat_in_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> state == ST_READ)
    else $error("read run ended before its last beat");

  a_conv_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && !conv_last) |=> state == ST_CONV)
    else $error("operand conversion cut short");

  a_conv_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !bit_chain[BCD_DIGITS])
    else $error("operand conversion overflowed the cell chain");

endmodule

@@ tb/sv/tb_decimal_digit_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_digit_accumulator: self-checking bench for the decimal accumulator
// Drives load, add, multiply and read beats and keeps a digit-level model of
// the stored number. Every read beat is checked against the predicted digits.
// ----------------------------------------------------------------------------
module tb_decimal_digit_accumulator;
  import dda_pkg::*;

  localparam int DIGITS = 40;
  // load, add and multiply: operand conversion plus one ring rotation
  localparam int OP_CYCLES = 31 + DIGITS;
  // settle time after the last expected beat, covers one trailing operation
  localparam int DRAIN_CYCLES = OP_CYCLES + 20;
  localparam logic [OPERAND_W-1:0] OPERAND_MAX = '1;
  localparam logic [OPERAND_W-1:0] BILLION = 31'd1_000_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Idle rates in percent, set per test phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Long receiver hold-off: the test posts a length, the stall process owns it.
  int hold_req  = 0;
  int hold_left = 0;

  // Predicted state of the stored number, least significant digit first.
  logic [DIGIT_W-1:0] number_digits [DIGITS];
  // Digit beats still owed by the block, oldest first.
  out_t digit_queue [$];

  int items_sent     = 0;
  int reads_sent     = 0;
  int beats_checked  = 0;
  int mismatch_count = 0;

  decimal_digit_accumulator #(
    .DIGITS(DIGITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Advance the digit model by one accepted beat and queue any read digits.
  task automatic predict_item(input in_t item);
    longint unsigned value;
    longint unsigned carry;
    longint unsigned acc;
    bit started;
    out_t beat;
    value = longint'(item.operand);
    carry = 0;
    started = 1'b0;
    items_sent++;
    case (item.op)
      OP_LOAD: begin
        for (int i = 0; i < DIGITS; i++) begin
          number_digits[i] = DIGIT_W'(value % 10);
          value = value / 10;
        end
      end
      OP_ADD: begin
        // ripple the operand's decimal digits in, drop the carry off the top
        for (int i = 0; i < DIGITS; i++) begin
          acc = longint'(number_digits[i]) + (value % 10) + carry;
          number_digits[i] = DIGIT_W'(acc % 10);
          carry = acc / 10;
          value = value / 10;
        end
      end
      OP_MUL: begin
        // exact product per digit; the carry is wide enough for any operand
        for (int i = 0; i < DIGITS; i++) begin
          acc = longint'(number_digits[i]) * value + carry;
          number_digits[i] = DIGIT_W'(acc % 10);
          carry = acc / 10;
        end
      end
      OP_READ: begin
        reads_sent++;
        // suppress leading zeros; once a digit is out, every lower one follows
        for (int i = DIGITS - 1; i > 0; i--) begin
          if (started || number_digits[i] != '0) begin
            started = 1'b1;
            beat.digit = number_digits[i];
            beat.last  = 1'b0;
            digit_queue.push_back(beat);
          end
        end
        beat.digit = number_digits[0];
        beat.last  = 1'b1;
        digit_queue.push_back(beat);
      end
      default: ;
    endcase
  endtask

  // Offer one beat at the falling edge and hold it until the block takes it.
  task automatic send_item(input op_t op, input logic [OPERAND_W-1:0] operand);
    in_t item;
    item.op      = op;
    item.operand = operand;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_item(item);
  endtask

  // Drop valid, wait for every owed digit, then let a trailing operation finish.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when one is posted.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Check each accepted output beat against the oldest owed digit.
  always @(posedge clk) begin : check_beat
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (digit_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat digit %0d last %0b",
                                  out_data.digit, out_data.last));
      end else begin
        want = digit_queue.pop_front();
        if (out_data.digit !== want.digit) begin
          report_mismatch($sformatf("digit got %0d want %0d",
                                    out_data.digit, want.digit));
        end
        if (out_data.last !== want.last) begin
          report_mismatch($sformatf("last got %0b want %0b (digit %0d)",
                                    out_data.last, want.last, want.digit));
        end
      end
    end
  end

  function automatic logic [OPERAND_W-1:0] pick_operand();
    case ($urandom_range(5))
      0:       return OPERAND_W'($urandom_range(9));
      1:       return OPERAND_W'($urandom_range(99_999));
      2:       return OPERAND_MAX;
      3:       return OPERAND_W'(1) << $urandom_range(OPERAND_W - 1);
      default: return OPERAND_W'($urandom());
    endcase
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 12) return OP_LOAD;
    if (r < 40) return OP_ADD;
    if (r < 65) return OP_MUL;
    return OP_READ;
  endfunction

  // A fresh block must read back a single zero.
  task automatic test_read_of_zero();
    send_item(OP_READ, OPERAND_MAX);
  endtask

  // Load zero, the widest operand, and one with a run of inner zeros.
  task automatic test_load_extremes();
    send_item(OP_LOAD, '0);
    send_item(OP_READ, '0);
    send_item(OP_LOAD, OPERAND_MAX);
    send_item(OP_READ, 31'h5555_5555);
    send_item(OP_LOAD, BILLION);
    send_item(OP_READ, 31'h2AAA_AAAA);
  endtask

  // Ripple a carry through a run of nines.
  task automatic test_add_carry();
    send_item(OP_LOAD, 31'd999_999_999);
    send_item(OP_ADD, 31'd1);
    send_item(OP_READ, '0);
  endtask

  // Multiply by one keeps the number, by zero clears it.
  task automatic test_multiply_cases();
    send_item(OP_LOAD, 31'd12_345);
    send_item(OP_MUL, 31'd1);
    send_item(OP_READ, '0);
    send_item(OP_MUL, '0);
    send_item(OP_READ, '0);
  endtask

  // Build a full row of nines, read it, then add one so it wraps to zero.
  task automatic test_wraparound();
    send_item(OP_LOAD, 31'd999_999_999);
    repeat (3) begin
      send_item(OP_MUL, BILLION);
      send_item(OP_ADD, 31'd999_999_999);
    end
    send_item(OP_MUL, 31'd10_000);
    send_item(OP_ADD, 31'd9_999);
    send_item(OP_READ, '0);
    send_item(OP_ADD, 31'd1);
    send_item(OP_READ, '0);
  endtask

  // Hold the receiver off for a long stretch while full-width reads keep
  // coming, so the block backs up and stalls its input; then drain.
  task automatic test_backpressure();
    send_item(OP_LOAD, OPERAND_MAX);
    repeat (5) send_item(OP_MUL, OPERAND_MAX - 31'($urandom_range(1000)));
    wait_drained();
    send_idle_pct = 0;
    hold_req = 400;
    repeat (4) send_item(OP_READ, '0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(pick_op(), pick_operand());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < DIGITS; i++) number_digits[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_read_of_zero();
    test_load_extremes();
    test_add_carry();
    test_multiply_cases();
    test_wraparound();
    wait_drained();
    test_backpressure();

    // receiver idles often first, then the sender, then neither
    test_random_mix(100, 34, 80);
    test_random_mix(100, 80, 34);
    test_random_mix(100, 0, 0);

    $display("Sent %0d items (%0d reads); checked %0d digit beats.",
             items_sent, reads_sent, beats_checked);
    $display("Covered load, add, multiply, read, wraparound and long output stall; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
